// File: sv/bqf_pkg.sv
// bqf_pkg: shared types and constants for the biquad section filter.
// Holds register indexes, datapath widths and the controller/datapath command set.
// No dependencies.
`default_nettype none
package bqf_pkg;

	// Field and datapath widths
	localparam int unsigned SampleW = 24;
	localparam int unsigned CoefW   = 32;
	localparam int unsigned StateW  = 48;
	localparam int unsigned ProdW   = CoefW + SampleW;   // full product
	localparam int unsigned ProdSh  = 20;                // product scaling shift
	localparam int unsigned OutSh   = 8;                 // state to sample shift
	localparam int unsigned TermW   = ProdW - ProdSh;    // scaled product
	localparam int unsigned AccW    = StateW + 2;        // feedback accumulator
	localparam int unsigned IdxW    = 3;

	// Configuration register indexes
	typedef enum logic [IdxW-1:0] {
		REG_ENABLE = 3'd0,
		REG_B0     = 3'd1,
		REG_B1     = 3'd2,
		REG_B2     = 3'd3,
		REG_A1     = 3'd4,
		REG_A2     = 3'd5
	} reg_idx_t;

	localparam logic [CoefW-1:0] B0Reset = 32'sd268435456;

	// Multiplier operand pair
	typedef enum logic [2:0] {
		MUL_B0_X = 3'd0,
		MUL_B1_X = 3'd1,
		MUL_A1_Y = 3'd2,
		MUL_B2_X = 3'd3,
		MUL_A2_Y = 3'd4
	} mul_sel_t;

	// Accumulator / state operation for one cycle
	typedef enum logic [2:0] {
		ACC_NONE    = 3'd0,
		ACC_OUT_Y   = 3'd1,   // y = sat24((p + d1) >>> 8)
		ACC_ADD_D2  = 3'd2,   // acc = p + d2
		ACC_SUB     = 3'd3,   // acc = acc - p
		ACC_WR_D1   = 3'd4,   // d1 = sat48(acc), acc = p
		ACC_WR_D2   = 3'd5    // d2 = sat48(acc - p)
	} acc_op_t;

	typedef struct packed {
		logic     load_in;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic filter_enable;
	} status_t;

endpackage
`default_nettype wire

// File: sv/bqf_ctrl.sv
// bqf_ctrl: sequencer for the biquad section; runs the five shared multiplies.
// Also owns the input and output handshakes. Depends on bqf_pkg.
`default_nettype none
module bqf_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire bqf_pkg::status_t status,
	output bqf_pkg::cmd_t        cmd
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MB0  = 8'b0000_0010,
		ST_Y    = 8'b0000_0100,
		ST_B1   = 8'b0000_1000,
		ST_A1   = 8'b0001_0000,
		ST_B2   = 8'b0010_0000,
		ST_A2   = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_acc;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d         = state_q;
		cmd.load_in     = 1'b0;
		cmd.mul_sel     = bqf_pkg::MUL_B0_X;
		cmd.acc_op      = bqf_pkg::ACC_NONE;
		cmd.load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load_in = in_acc;
				if (in_acc) begin
					state_d = status.filter_enable ? ST_MB0 : ST_DONE;
				end
			end
			ST_MB0: begin
				cmd.mul_sel = bqf_pkg::MUL_B0_X;
				state_d     = ST_Y;
			end
			ST_Y: begin
				cmd.mul_sel = bqf_pkg::MUL_B1_X;
				cmd.acc_op  = bqf_pkg::ACC_OUT_Y;
				state_d     = ST_B1;
			end
			ST_B1: begin
				cmd.mul_sel = bqf_pkg::MUL_A1_Y;
				cmd.acc_op  = bqf_pkg::ACC_ADD_D2;
				state_d     = ST_A1;
			end
			ST_A1: begin
				cmd.mul_sel = bqf_pkg::MUL_B2_X;
				cmd.acc_op  = bqf_pkg::ACC_SUB;
				state_d     = ST_B2;
			end
			ST_B2: begin
				cmd.mul_sel = bqf_pkg::MUL_A2_Y;
				cmd.acc_op  = bqf_pkg::ACC_WR_D1;
				state_d     = ST_A2;
			end
			ST_A2: begin
				cmd.acc_op = bqf_pkg::ACC_WR_D2;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state and track the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/bqf_dp.sv
// bqf_dp: biquad datapath with configuration registers, one shared multiplier,
// accumulator, the two delay states and the output register. Depends on bqf_pkg.
`default_nettype none
module bqf_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [bqf_pkg::IdxW-1:0]            cfg_index,
	input  wire logic [bqf_pkg::CoefW-1:0]           cfg_data,
	input  wire logic signed [bqf_pkg::SampleW-1:0]  sample_in,
	input  wire logic                                block_end,
	input  wire bqf_pkg::cmd_t                       cmd,
	output bqf_pkg::status_t                         status,
	output logic signed [bqf_pkg::SampleW-1:0]       sample_out,
	output logic                                     block_end_out
);

	localparam int unsigned SampleW = bqf_pkg::SampleW;
	localparam int unsigned CoefW   = bqf_pkg::CoefW;
	localparam int unsigned StateW  = bqf_pkg::StateW;
	localparam int unsigned ProdW   = bqf_pkg::ProdW;
	localparam int unsigned TermW   = bqf_pkg::TermW;
	localparam int unsigned AccW    = bqf_pkg::AccW;
	localparam int unsigned YAccW   = StateW + 1;
	localparam int unsigned YShW    = YAccW - bqf_pkg::OutSh;

	logic                      enable_q;
	logic signed [CoefW-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [SampleW-1:0] x_q, y_q;
	logic                      be_q;
	logic signed [ProdW-1:0]   prod_q;
	logic signed [AccW-1:0]    acc_q;
	logic signed [StateW-1:0]  d1_q, d2_q;
	logic signed [SampleW-1:0] out_q;
	logic                      out_be_q;

	logic signed [CoefW-1:0]   mul_c;
	logic signed [SampleW-1:0] mul_s;
	logic signed [ProdW-1:0]   prod_d;
	logic signed [TermW-1:0]   term;
	logic signed [AccW-1:0]    term_x;
	logic signed [YAccW-1:0]   y_sum;
	logic signed [YShW-1:0]    y_sh;
	logic signed [SampleW-1:0] y_sat;
	logic signed [AccW-1:0]    diff;

	assign status.filter_enable = enable_q;
	assign sample_out           = out_q;
	assign block_end_out        = out_be_q;

	// Write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			b0_q     <= bqf_pkg::B0Reset;
			b1_q     <= '0;
			b2_q     <= '0;
			a1_q     <= '0;
			a2_q     <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				bqf_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				bqf_pkg::REG_B0:     b0_q     <= cfg_data;
				bqf_pkg::REG_B1:     b1_q     <= cfg_data;
				bqf_pkg::REG_B2:     b2_q     <= cfg_data;
				bqf_pkg::REG_A1:     a1_q     <= cfg_data;
				bqf_pkg::REG_A2:     a2_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Select multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			bqf_pkg::MUL_B0_X: begin mul_c = b0_q; mul_s = x_q; end
			bqf_pkg::MUL_B1_X: begin mul_c = b1_q; mul_s = x_q; end
			bqf_pkg::MUL_A1_Y: begin mul_c = a1_q; mul_s = y_q; end
			bqf_pkg::MUL_B2_X: begin mul_c = b2_q; mul_s = x_q; end
			bqf_pkg::MUL_A2_Y: begin mul_c = a2_q; mul_s = y_q; end
			default:           begin mul_c = b0_q; mul_s = x_q; end
		endcase
	end

	assign prod_d = ProdW'(mul_c) * ProdW'(mul_s);

	// Scaled product: arithmetic shift, rounds toward negative infinity
	assign term   = prod_q[ProdW-1:bqf_pkg::ProdSh];
	assign term_x = AccW'(term);

	// Output sample from b0 term and first state
	assign y_sum = YAccW'(term) + YAccW'(d1_q);
	assign y_sh  = y_sum[YAccW-1:bqf_pkg::OutSh];
	always_comb begin
		if (y_sh[YShW-1:SampleW-1] == {(YShW-SampleW+1){y_sh[YShW-1]}}) begin
			y_sat = y_sh[SampleW-1:0];
		end else begin
			y_sat = {y_sh[YShW-1], {(SampleW-1){!y_sh[YShW-1]}}};
		end
	end

	assign diff = acc_q - term_x;

	function automatic logic signed [StateW-1:0] sat48(input logic signed [AccW-1:0] v);
		logic signed [StateW-1:0] r;
		if (v[AccW-1:StateW-1] == {(AccW-StateW+1){v[AccW-1]}}) begin
			r = v[StateW-1:0];
		end else begin
			r = {v[AccW-1], {(StateW-1){!v[AccW-1]}}};
		end
		return r;
	endfunction

	// Delay states clear at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			case (cmd.acc_op)
				bqf_pkg::ACC_WR_D1: d1_q <= sat48(acc_q);
				bqf_pkg::ACC_WR_D2: d2_q <= sat48(diff);
				default: begin
				end
			endcase
		end
	end

	// Operand, product, accumulator and output registers
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (cmd.load_in) begin
			x_q  <= sample_in;
			y_q  <= sample_in;
			be_q <= block_end;
		end
		case (cmd.acc_op)
			bqf_pkg::ACC_OUT_Y:  y_q   <= y_sat;
			bqf_pkg::ACC_ADD_D2: acc_q <= term_x + AccW'(d2_q);
			bqf_pkg::ACC_SUB:    acc_q <= diff;
			bqf_pkg::ACC_WR_D1:  acc_q <= term_x;
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			out_q    <= y_q;
			out_be_q <= be_q;
		end
	end

endmodule
`default_nettype wire

// File: sv/biquad_section_filter_top.sv
// biquad_section_filter_top: one transposed direct form II biquad section.
// Instantiates bqf_ctrl and bqf_dp; depends on bqf_pkg.
//
//   channel   signals                                   transfer
//   input     in_valid, in_ready, sample_in, block_end  valid & ready at clk edge
//   output    out_valid, out_ready, sample_out,         valid & ready at clk edge
//             block_end_out
//   config    cfg_write, cfg_index, cfg_data            cfg_write at clk edge
//
// Filtering: after acceptance the sequencer steps from ST_MB0 through ST_A2 to
// ST_DONE, which loads the output register; five multiplies share one registered
// 32x24 multiplier. A disabled section goes to ST_DONE and holds its state.
// arst_n clears the delay states and loads coefficient reset values.
// A result waiting in the output register holds the sequencer in its last step;
// the next sample is accepted as soon as the sequencer is idle.
`default_nettype none
module biquad_section_filter_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [bqf_pkg::SampleW-1:0]  sample_in,
	input  wire logic                                block_end,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [bqf_pkg::SampleW-1:0]       sample_out,
	output logic                                     block_end_out,
	input  wire logic                                cfg_write,
	input  wire logic [bqf_pkg::IdxW-1:0]            cfg_index,
	input  wire logic [bqf_pkg::CoefW-1:0]           cfg_data
);

	bqf_pkg::cmd_t    cmd;
	bqf_pkg::status_t status;

	bqf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	bqf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_in     (sample_in),
		.block_end     (block_end),
		.cmd           (cmd),
		.status        (status),
		.sample_out    (sample_out),
		.block_end_out (block_end_out)
	);

endmodule
`default_nettype wire
